FILE: rtl/core/hte_pkg.sv
// Shared types and constants for the Huffman table encoder.
// No dependencies; imported by all modules in rtl/core.
package hte_pkg;

	localparam int SYMBOL_COUNT    = 256;
	localparam int SYMBOL_WIDTH    = 8;
	localparam int MAX_CODE_LENGTH = 16;
	localparam int VALUE_BITS      = 16;
	localparam int LEN_CAP         = (MAX_CODE_LENGTH < VALUE_BITS) ? MAX_CODE_LENGTH
	                                                                : VALUE_BITS;
	localparam int LEN_W    = 5;
	localparam int BYTE_W   = 8;
	localparam int PEND_W   = 7;
	localparam int PCNT_W   = 3;
	localparam int ACC_W    = PEND_W + VALUE_BITS;
	localparam int TOTAL_W  = 24;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [TOTAL_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		FUNC_LOAD   = 2'd0,
		FUNC_ENCODE = 2'd1,
		FUNC_FLUSH  = 2'd2,
		FUNC_NONE   = 2'd3
	} func_t;

	typedef struct packed {
		logic [LEN_W-1:0]      len;
		logic [VALUE_BITS-1:0] value;
	} code_entry_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_bytes;
		logic               last;
		logic               has_byte;
		logic [BYTE_W-1:0]  out_byte;
	} result_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + TOTAL_W'(1);
	endfunction

endpackage

FILE: rtl/core/huffman_table_encoder.sv
// Static Huffman encoder top level: code table, bit packer, result queue.
// Depends on hte_pkg, hte_code_table and hte_result_fifo.
// A request's results pass the stage-1 register and code table read, then the result queue, before they are offered.
// Throughput: one request per cycle while the result queue has room; the single output port gives one byte per
// cycle while m_tready is high, so requests that finish two bytes each stall input to that rate.
// Reset (arst_n low) clears the table valid bits, packer state and queue at once.
module huffman_table_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // symbol[7:0], code_value[23:8], code_length[28:24], zero
	input  logic [1:0]  s_tuser,  // func[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // out_byte[7:0], total_bytes[31:8]
	output logic        m_tuser,  // has_byte
	output logic        m_tlast
);
	import hte_pkg::*;

	logic [SYMBOL_WIDTH-1:0] in_symbol;
	logic [VALUE_BITS-1:0]   in_value;
	logic [LEN_W-1:0]        in_len;
	logic [LEN_W-1:0]        cap_len;
	logic [VALUE_BITS:0]     len_mask;
	code_entry_t             wr_entry;
	code_entry_t             entry;
	logic                    s_accept;

	logic                    s1_valid_s1;
	func_t                   func_s1;
	logic                    s1_fire;
	logic                    room;

	logic [PEND_W-1:0]       pend_q;
	logic [PCNT_W-1:0]       pcnt_q;
	logic [TOTAL_W-1:0]      bytes_q;

	logic [ACC_W-1:0]        acc;
	logic [LEN_W-1:0]        total;
	logic [1:0]              nbytes;
	logic [ACC_W-1:0]        sh0;
	logic [ACC_W-1:0]        sh1;
	logic [PEND_W:0]         pmask;
	logic [BYTE_W-1:0]       fbyte;
	logic [TOTAL_W-1:0]      cnt1;
	logic [TOTAL_W-1:0]      cnt2;
	logic [1:0]              push_n;
	result_t                 res0;
	result_t                 res1;
	result_t                 out_res;

	assign in_symbol = s_tdata[7:0];
	assign in_value  = s_tdata[23:8];
	assign in_len    = s_tdata[28:24];
	assign s_tready  = !s1_valid_s1 || s1_fire;
	assign s_accept  = s_tvalid && s_tready;

	// Load: saturate length, keep only the low length bits of the code.
	assign cap_len  = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;
	assign len_mask = ((VALUE_BITS+1)'(1) << cap_len) - (VALUE_BITS+1)'(1);
	assign wr_entry.len   = cap_len;
	assign wr_entry.value = in_value & len_mask[VALUE_BITS-1:0];

	hte_code_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (s_accept),
		.rd_addr (in_symbol),
		.wr_en   (s_accept && (func_t'(s_tuser) == FUNC_LOAD)),
		.wr_addr (in_symbol),
		.wr_data (wr_entry),
		.rd_data (entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			s1_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			func_s1 <= func_t'(s_tuser);
		end
	end

	assign s1_fire = s1_valid_s1 && room;

	// Bit packer: append code below pending bits, peel off whole bytes.
	always_comb begin
		acc    = (ACC_W'(pend_q) << entry.len) | ACC_W'(entry.value);
		total  = LEN_W'(pcnt_q) + entry.len;
		nbytes = total[4:3];
		sh0    = acc >> (total - LEN_W'(8));
		sh1    = acc >> (total - LEN_W'(16));
		pmask  = ((PEND_W+1)'(1) << total[2:0]) - (PEND_W+1)'(1);
		fbyte  = BYTE_W'({1'b0, pend_q} << (4'd8 - {1'b0, pcnt_q}));
		cnt1   = sat_inc(bytes_q);
		cnt2   = sat_inc(cnt1);
		push_n = 2'd0;
		res0   = '0;
		res1   = '0;
		res1.out_byte    = sh1[BYTE_W-1:0];
		res1.has_byte    = 1'b1;
		res1.total_bytes = cnt2;
		case (func_s1)
			FUNC_ENCODE: begin
				push_n           = nbytes;
				res0.out_byte    = sh0[BYTE_W-1:0];
				res0.has_byte    = 1'b1;
				res0.total_bytes = cnt1;
			end
			FUNC_FLUSH: begin
				push_n = 2'd1;
				res0.last = 1'b1;
				if (pcnt_q != '0) begin
					res0.out_byte    = fbyte;
					res0.has_byte    = 1'b1;
					res0.total_bytes = cnt1;
				end else begin
					res0.total_bytes = bytes_q;
				end
			end
			default: begin
				push_n = 2'd0;
			end
		endcase
		if (!s1_fire) begin
			push_n = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q  <= '0;
			pcnt_q  <= '0;
			bytes_q <= '0;
		end else if (s1_fire) begin
			case (func_s1)
				FUNC_ENCODE: begin
					pend_q  <= acc[PEND_W-1:0] & pmask[PEND_W-1:0];
					pcnt_q  <= total[2:0];
					bytes_q <= (nbytes == 2'd2) ? cnt2 : (nbytes == 2'd1) ? cnt1 : bytes_q;
				end
				FUNC_FLUSH: begin
					pend_q  <= '0;
					pcnt_q  <= '0;
					bytes_q <= '0;
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	hte_result_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (push_n),
		.push_data0 (res0),
		.push_data1 (res1),
		.room       (room),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (out_res)
	);

	assign m_tdata = {out_res.total_bytes, out_res.out_byte};
	assign m_tuser = out_res.has_byte;
	assign m_tlast = out_res.last;

endmodule

FILE: rtl/core/hte_code_table.sv
// Code table: one memory of code entries plus per-entry valid bits.
// Depends on hte_pkg. Entries never written read back as zero length.
module hte_code_table (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            rd_en,
	input  logic [hte_pkg::SYMBOL_WIDTH-1:0] rd_addr,
	input  logic                            wr_en,
	input  logic [hte_pkg::SYMBOL_WIDTH-1:0] wr_addr,
	input  hte_pkg::code_entry_t            wr_data,
	output hte_pkg::code_entry_t            rd_data
);
	import hte_pkg::*;

	code_entry_t             mem [SYMBOL_COUNT];
	logic [SYMBOL_COUNT-1:0] valid_q;
	code_entry_t             rd_data_q;
	logic                    rd_valid_q;
	logic                    wr_ok;
	logic                    rd_ok;

	assign wr_ok = wr_en && ({1'b0, wr_addr} < (SYMBOL_WIDTH+1)'(SYMBOL_COUNT));
	assign rd_ok = {1'b0, rd_addr} < (SYMBOL_WIDTH+1)'(SYMBOL_COUNT);

	always_ff @(posedge clk) begin
		if (wr_ok) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_ok) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= rd_ok && valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

FILE: rtl/core/hte_result_fifo.sv
// Small result queue: takes up to two results per cycle, gives one when out_ready is high.
// Depends on hte_pkg.
module hte_result_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  hte_pkg::result_t  push_data0,
	input  hte_pkg::result_t  push_data1,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output hte_pkg::result_t  out_data
);
	import hte_pkg::*;

	result_t              buf_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_AW:0]     count_q;
	logic                 pop;

	assign out_valid = count_q != '0;
	assign out_data  = buf_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign room      = count_q <= (FIFO_AW+1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			buf_q[wr_ptr_q] <= push_data0;
		end
		if (push_n == 2'd2) begin
			buf_q[wr_ptr_q + FIFO_AW'(1)] <= push_data1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + FIFO_AW'(push_n);
			rd_ptr_q <= rd_ptr_q + FIFO_AW'(pop);
			count_q  <= count_q + (FIFO_AW+1)'(push_n) - (FIFO_AW+1)'(pop);
		end
	end

endmodule
